>>> sv/assert_macros.svh
// Assertion macros shared by the easing curve interpolator RTL.
// Each macro expects signals named clk and rst in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ECI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequence follows in the same cycle
`define ECI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/eci_pkg.sv
// Package for the easing curve interpolator: input codes, work classes and
// the control record passed from the front end to the back end. No dependencies.
`default_nettype none

package eci_pkg;

  localparam int VALUE_W = 16;
  localparam int PROG_W  = 17;
  localparam int EASED_W = 17;

  localparam int OUT_LOW  = -40000;
  localparam int OUT_HIGH = 40000;

  // curve select codes on the input port
  localparam logic [2:0] CURVE_BACK   = 3'd0;
  localparam logic [2:0] CURVE_BOUNCE = 3'd1;
  localparam logic [2:0] CURVE_CIRC   = 3'd2;
  localparam logic [2:0] CURVE_QUINT  = 3'd3;
  localparam logic [2:0] CURVE_CUBIC  = 3'd4;

  // direction mode codes on the input port
  localparam logic [1:0] MODE_IN     = 2'd0;
  localparam logic [1:0] MODE_OUT    = 2'd1;
  localparam logic [1:0] MODE_IN_OUT = 2'd2;

  typedef enum logic [2:0] {
    KIND_BACK,
    KIND_BOUNCE,
    KIND_CIRC,
    KIND_QUINT,
    KIND_CUBIC,
    KIND_LINEAR
  } kind_t;

  // ease in, ease out, in-out first half, in-out second half
  typedef enum logic [1:0] {
    SHAPE_IN,
    SHAPE_OUT,
    SHAPE_LOW,
    SHAPE_HIGH
  } shape_t;

  // bounce segment: rising arc, then the three rebounds
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_B1,
    SEG_B2,
    SEG_B3
  } seg_t;

  typedef struct packed {
    kind_t  kind;
    shape_t shape;
    seg_t   seg;
  } ctl_t;

endpackage

`default_nettype wire

>>> sv/eci_front.sv
// Front end: takes a command beat, normalizes progress and classifies the
// curve into a work class and operand. Depends on eci_pkg.
`default_nettype none

module eci_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [15:0]          start_value,
  input  wire logic signed [15:0]          end_value,
  input  wire logic [16:0]                 progress,
  input  wire logic [2:0]                  curve,
  input  wire logic [1:0]                  mode,
  input  wire logic                        q_full,
  output logic                             push,
  output logic signed [FRACTION_BITS+7:0]  x,
  output logic [FRACTION_BITS:0]           t,
  output logic signed [15:0]               base,
  output logic signed [16:0]               diff,
  output eci_pkg::ctl_t                    ctl
);

  localparam int F  = FRACTION_BITS;
  localparam int W  = F + 8;
  localparam int TW = F + 1;
  localparam longint ONE_L = longint'(1) << F;
  localparam logic signed [W-1:0] ONE  = W'(ONE_L);
  localparam logic signed [W-1:0] TWO  = W'(2 * ONE_L);
  localparam logic signed [W-1:0] FOUR = W'(4 * ONE_L);
  localparam logic signed [W-1:0] SIX  = W'(6 * ONE_L);
  localparam logic signed [W-1:0] EIGHT = W'(8 * ONE_L);
  localparam logic signed [W-1:0] NINE = W'(9 * ONE_L);
  localparam logic signed [W-1:0] TEN  = W'(10 * ONE_L);
  localparam logic signed [W-1:0] TWENTY_ONE = W'(21 * ONE_L);

  logic                   valid;
  logic                   load;
  logic                   accept;
  logic [16:0]            p_sat;
  logic [TW-1:0]          t_cur;
  logic signed [W-1:0]    tt;
  logic signed [W-1:0]    arg;
  logic signed [W-1:0]    a11;
  logic signed [W-1:0]    x_next;
  logic                   low;
  eci_pkg::ctl_t          ctl_next;

  // saturate progress at one and bring it to F fraction bits
  assign p_sat = (progress > 17'd65536) ? 17'd65536 : progress;

  if (F >= 16) begin : g_widen
    assign t_cur = TW'(p_sat) << (F - 16);
  end else begin : g_narrow
    assign t_cur = TW'(p_sat >> (16 - F));
  end

  // classify the command and form the polynomial or bounce operand
  always_comb begin
    tt  = signed'({{(W - TW){1'b0}}, t_cur});
    low = t_cur < TW'(ONE_L >> 1);
    arg = tt;
    a11 = '0;
    x_next = tt;
    ctl_next.seg = eci_pkg::SEG_RISE;

    unique case (curve)
      eci_pkg::CURVE_BACK:   ctl_next.kind = eci_pkg::KIND_BACK;
      eci_pkg::CURVE_BOUNCE: ctl_next.kind = eci_pkg::KIND_BOUNCE;
      eci_pkg::CURVE_CIRC:   ctl_next.kind = eci_pkg::KIND_CIRC;
      eci_pkg::CURVE_QUINT:  ctl_next.kind = eci_pkg::KIND_QUINT;
      eci_pkg::CURVE_CUBIC:  ctl_next.kind = eci_pkg::KIND_CUBIC;
      default:               ctl_next.kind = eci_pkg::KIND_LINEAR;
    endcase

    unique case (mode)
      eci_pkg::MODE_IN:  ctl_next.shape = eci_pkg::SHAPE_IN;
      eci_pkg::MODE_OUT: ctl_next.shape = eci_pkg::SHAPE_OUT;
      default:           ctl_next.shape = low ? eci_pkg::SHAPE_LOW : eci_pkg::SHAPE_HIGH;
    endcase

    case (ctl_next.kind) inside
      eci_pkg::KIND_BACK, eci_pkg::KIND_CIRC: begin
        case (ctl_next.shape)
          eci_pkg::SHAPE_IN:  x_next = tt;
          eci_pkg::SHAPE_OUT: x_next = tt - ONE;
          eci_pkg::SHAPE_LOW: x_next = tt <<< 1;
          default:            x_next = (tt <<< 1) - TWO;
        endcase
      end
      eci_pkg::KIND_QUINT, eci_pkg::KIND_CUBIC: begin
        case (ctl_next.shape)
          eci_pkg::SHAPE_IN:  x_next = tt;
          eci_pkg::SHAPE_OUT: x_next = ONE - tt;
          eci_pkg::SHAPE_LOW: x_next = tt <<< 1;
          default:            x_next = TWO - (tt <<< 1);
        endcase
      end
      eci_pkg::KIND_BOUNCE: begin
        // every bounce form is built on the ease-out arc
        case (ctl_next.shape)
          eci_pkg::SHAPE_IN:  arg = ONE - tt;
          eci_pkg::SHAPE_OUT: arg = tt;
          eci_pkg::SHAPE_LOW: arg = ONE - (tt <<< 1);
          default:            arg = (tt <<< 1) - ONE;
        endcase
        a11 = (arg <<< 3) + (arg <<< 1) + arg;
        if (a11 < FOUR) begin
          x_next = a11;
          ctl_next.seg = eci_pkg::SEG_RISE;
        end else if (a11 < EIGHT) begin
          x_next = a11 - SIX;
          ctl_next.seg = eci_pkg::SEG_B1;
        end else if (a11 < TEN) begin
          x_next = a11 - NINE;
          ctl_next.seg = eci_pkg::SEG_B2;
        end else begin
          x_next = (a11 <<< 1) - TWENTY_ONE;
          ctl_next.seg = eci_pkg::SEG_B3;
        end
      end
      default: x_next = tt;
    endcase
  end

  // hold the staged beat while the queue is full
  assign busy   = rst || (valid && q_full);
  assign accept = start && !busy;
  assign load   = !valid || !q_full;
  assign push   = valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (load && accept) begin
      x    <= x_next;
      t    <= t_cur;
      base <= start_value;
      diff <= {end_value[15], end_value} - {start_value[15], start_value};
      ctl  <= ctl_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/eci_queue.sv
// Short FIFO between the front end and the back end.
// Generic payload width; uses the shared assertion macros.
`default_nettype none
`include "assert_macros.svh"

module eci_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty,
  output logic                  full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == CW'(DEPTH));
  assign dout  = mem[rd_ptr];

  // store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ECI_ASSERT(a_cnt_range, cnt <= CW'(DEPTH), "queue fill count beyond depth")
  `ECI_ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into a full queue")

endmodule

`default_nettype wire

>>> sv/eci_back.sv
// Back end: fixed-depth pipeline computing the eased weight (products,
// pipelined square root, combine) and the final interpolation. Depends on eci_pkg.
`default_nettype none

module eci_back #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic signed [FRACTION_BITS+7:0] x,
  input  wire logic [FRACTION_BITS:0]      t,
  input  wire logic signed [15:0]          base,
  input  wire logic signed [16:0]          diff,
  input  wire eci_pkg::ctl_t               ctl,
  output logic                             done,
  output logic signed [16:0]               eased_value
);

  localparam int F   = FRACTION_BITS;
  localparam int W   = F + 8;
  localparam int W2  = 2 * W;
  localparam int TW  = F + 1;
  localparam int RW  = 2 * F + 2;
  localparam int NSQ = F + 1;
  localparam int PW  = 17 + W;
  localparam longint ONE_L = longint'(1) << F;
  localparam logic signed [W-1:0] ONE  = W'(ONE_L);
  localparam logic signed [W-1:0] TWO  = W'(2 * ONE_L);
  localparam logic signed [W-1:0] HALF = W'(ONE_L >> 1);
  localparam logic signed [W-1:0] C1  = W'(((longint'(170158) << F) + 50000) / 100000);
  localparam logic signed [W-1:0] C3  = W'(((longint'(270158) << F) + 50000) / 100000);
  localparam logic signed [W-1:0] C2  =
    W'(((longint'(25949095) << F) + 5000000) / 10000000);
  localparam logic signed [W-1:0] C2P =
    W'(((longint'(35949095) << F) + 5000000) / 10000000);
  localparam logic signed [W-1:0] BASE1 = W'((3 * ONE_L) / 4);
  localparam logic signed [W-1:0] BASE2 = W'((15 * ONE_L) / 16);
  localparam logic signed [W-1:0] BASE3 = W'((63 * ONE_L) / 64);
  localparam logic [W2-1:0] RND_F  = W2'(1) << (F - 1);
  localparam logic [W2-1:0] RND_B4 = W2'(1) << (F + 3);
  localparam logic [W2-1:0] RND_B6 = W2'(1) << (F + 5);
  localparam logic [PW-1:0] RND_P  = PW'(1) << (F - 1);
  localparam logic signed [PW:0] LOW_V  = (PW + 1)'(eci_pkg::OUT_LOW);
  localparam logic signed [PW:0] HIGH_V = (PW + 1)'(eci_pkg::OUT_HIGH);

  typedef struct packed {
    eci_pkg::ctl_t       ctl;
    logic signed [W-1:0] x;
    logic [TW-1:0]       t;
    logic signed [15:0]  base;
    logic signed [16:0]  diff;
    logic signed [W-1:0] p2;
    logic signed [W-1:0] bb;
    logic signed [W-1:0] m;
    logic signed [W-1:0] p3;
    logic signed [W-1:0] pb;
    logic signed [W-1:0] p4;
    logic signed [W-1:0] a3;
    logic signed [W-1:0] p5;
    logic [TW-1:0]       rad;
    logic [RW-1:0]       rem;
    logic [RW-1:0]       root;
  } rec_t;

  // round a double-width product to F fraction bits, ties away from zero
  function automatic logic signed [W-1:0] rnd_prod(input logic signed [W2-1:0] pr);
    logic [W2-1:0] mg;
    mg = pr[W2-1] ? $unsigned(-pr) : $unsigned(pr);
    mg = (mg + RND_F) >> F;
    return pr[W2-1] ? -$signed(mg[W-1:0]) : $signed(mg[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [W2-1:0] pr;
    pr = W2'(a) * W2'(b);
    return rnd_prod(pr);
  endfunction

  function automatic logic signed [W-1:0] qhalf(input logic signed [W-1:0] a);
    logic [W-1:0] mg;
    mg = a[W-1] ? $unsigned(-a) : $unsigned(a);
    mg = (mg + W'(1)) >> 1;
    return a[W-1] ? -$signed(mg) : $signed(mg);
  endfunction

  logic                 v1, v2, v3;
  logic                 sv [NSQ+1];
  rec_t                 r1, r2, r3;
  rec_t                 sq [NSQ+1];
  rec_t                 s1_next, s2_next, s3_next, s4_next;
  logic signed [W2-1:0] sqr;
  logic [W2-1:0]        sqr_u;
  logic signed [W-1:0]  opnd;
  logic signed [W-1:0]  rad_s;

  // stage 1: square the operand, bounce arc and back in-out slope
  always_comb begin
    s1_next      = '0;
    s1_next.ctl  = ctl;
    s1_next.x    = x;
    s1_next.t    = t;
    s1_next.base = base;
    s1_next.diff = diff;
    sqr   = W2'(x) * W2'(x);
    sqr_u = $unsigned(sqr);
    s1_next.p2 = rnd_prod(sqr);
    if (ctl.seg == eci_pkg::SEG_B3) begin
      s1_next.bb = $signed(W'((sqr_u + RND_B6) >> (F + 6)));
    end else begin
      s1_next.bb = $signed(W'((sqr_u + RND_B4) >> (F + 4)));
    end
    s1_next.m = qmul(C2P, x);
  end

  // stage 2: cube, back second product, circle radicand
  always_comb begin
    s2_next = r1;
    case (r1.ctl.shape)
      eci_pkg::SHAPE_LOW:  opnd = r1.m - C2;
      eci_pkg::SHAPE_HIGH: opnd = r1.m + C2;
      default:             opnd = C1;
    endcase
    s2_next.p3 = qmul(r1.p2, r1.x);
    s2_next.pb = qmul(r1.p2, opnd);
    rad_s = ONE - r1.p2;
    if (r1.ctl.kind != eci_pkg::KIND_CIRC || rad_s[W-1]) begin
      s2_next.rad = '0;
    end else begin
      s2_next.rad = rad_s[TW-1:0];
    end
  end

  // stage 3: fourth power and scaled cube
  always_comb begin
    s3_next    = r2;
    s3_next.p4 = qmul(r2.p3, r2.x);
    s3_next.a3 = qmul(C3, r2.p3);
  end

  // stage 4: fifth power, seed the root extraction
  always_comb begin
    s4_next      = r3;
    s4_next.p5   = qmul(r3.p4, r3.x);
    s4_next.rem  = RW'(r3.rad) << F;
    s4_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      sv[0] <= 1'b0;
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      sv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    r1    <= s1_next;
    r2    <= s2_next;
    r3    <= s3_next;
    sq[0] <= s4_next;
  end

  // root extraction: one result bit per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (F - j));
    rec_t          nx;
    logic [RW-1:0] trial;

    always_comb begin
      nx    = sq[j];
      trial = sq[j].root + BIT;
      if (sq[j].rem >= trial) begin
        nx.rem  = sq[j].rem - trial;
        nx.root = (sq[j].root >> 1) + BIT;
      end else begin
        nx.root = sq[j].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j+1] <= 1'b0;
      end else begin
        sv[j+1] <= sv[j];
      end
    end

    always_ff @(posedge clk) begin
      sq[j+1] <= nx;
    end
  end

  rec_t                rs;
  logic signed [W-1:0] pq;
  logic signed [W-1:0] bo;
  logic signed [W-1:0] sr;
  logic signed [W-1:0] w_next;
  logic signed [W-1:0] wt;
  logic signed [15:0]  base_c;
  logic signed [16:0]  diff_c;
  logic                vc;

  // combine the partial results into the eased weight
  always_comb begin
    rs = sq[NSQ];
    pq = (rs.ctl.kind == eci_pkg::KIND_QUINT) ? rs.p5 : rs.p3;
    sr = signed'({{(W - TW){1'b0}}, rs.root[TW-1:0]});
    case (rs.ctl.seg)
      eci_pkg::SEG_B1: bo = rs.bb + BASE1;
      eci_pkg::SEG_B2: bo = rs.bb + BASE2;
      eci_pkg::SEG_B3: bo = rs.bb + BASE3;
      default:         bo = rs.bb;
    endcase
    case (rs.ctl.kind) inside
      eci_pkg::KIND_BACK: begin
        case (rs.ctl.shape)
          eci_pkg::SHAPE_IN:  w_next = rs.a3 - rs.pb;
          eci_pkg::SHAPE_OUT: w_next = ONE + rs.a3 + rs.pb;
          eci_pkg::SHAPE_LOW: w_next = qhalf(rs.pb);
          default:            w_next = qhalf(rs.pb + TWO);
        endcase
      end
      eci_pkg::KIND_BOUNCE: begin
        case (rs.ctl.shape)
          eci_pkg::SHAPE_IN:  w_next = ONE - bo;
          eci_pkg::SHAPE_OUT: w_next = bo;
          eci_pkg::SHAPE_LOW: w_next = qhalf(ONE - bo);
          default:            w_next = qhalf(bo) + HALF;
        endcase
      end
      eci_pkg::KIND_CIRC: begin
        case (rs.ctl.shape)
          eci_pkg::SHAPE_IN:  w_next = ONE - sr;
          eci_pkg::SHAPE_OUT: w_next = sr;
          eci_pkg::SHAPE_LOW: w_next = qhalf(ONE - sr);
          default:            w_next = qhalf(sr + ONE);
        endcase
      end
      eci_pkg::KIND_QUINT, eci_pkg::KIND_CUBIC: begin
        case (rs.ctl.shape)
          eci_pkg::SHAPE_IN:  w_next = pq;
          eci_pkg::SHAPE_OUT: w_next = ONE - pq;
          eci_pkg::SHAPE_LOW: w_next = qhalf(pq);
          default:            w_next = ONE - qhalf(pq);
        endcase
      end
      default: w_next = signed'({{(W - TW){1'b0}}, rs.t});
    endcase
  end

  logic                 vm;
  logic signed [PW-1:0] prod;
  logic signed [15:0]   base_m;
  logic [PW-1:0]        pm_mag;
  logic signed [PW:0]   r_sum;
  logic signed [PW-1:0] r_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc   <= 1'b0;
      vm   <= 1'b0;
      done <= 1'b0;
    end else begin
      vc   <= sv[NSQ];
      vm   <= vc;
      done <= vm;
    end
  end

  // scale the span by the weight
  always_ff @(posedge clk) begin
    wt     <= w_next;
    base_c <= rs.base;
    diff_c <= rs.diff;
    prod   <= PW'(diff_c) * PW'(wt);
    base_m <= base_c;
  end

  // round, add the start value and saturate
  always_comb begin
    pm_mag = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);
    pm_mag = (pm_mag + RND_P) >> F;
    r_rnd  = prod[PW-1] ? -$signed(pm_mag) : $signed(pm_mag);
    r_sum  = (PW + 1)'(base_m) + (PW + 1)'(r_rnd);
  end

  always_ff @(posedge clk) begin
    if (r_sum < LOW_V) begin
      eased_value <= LOW_V[16:0];
    end else if (r_sum > HIGH_V) begin
      eased_value <= HIGH_V[16:0];
    end else begin
      eased_value <= r_sum[16:0];
    end
  end

endmodule

`default_nettype wire

>>> sv/easing_curve_interpolator.sv
// Easing curve interpolator top level: front end, beat queue and back end.
// Depends on eci_pkg, eci_front, eci_queue, eci_back and assert_macros.svh.
//
// Use: drive start_value, end_value, progress (Q1.16, 65536 is one), curve and
// mode with start high; the beat is taken at a rising edge where start is high
// and busy is low. Each beat yields one result: done is high for one cycle
// with eased_value = start + w(t) * (end - start), saturated to +/-40000.
// The result is registered through the front end, the beat queue and the back end.
// The back-end depth is set by the pipelined square root, one result bit per stage
// over FRACTION_BITS + 1 stages, ahead of the combine, multiply and output registers.
// Throughput: one beat per cycle, sustained; busy stays low in operation.
// Reset (rst, synchronous): busy is held high, all pipeline valids clear and
// no result strobe is issued until new beats arrive.
// Results cannot be held off: the receiver takes each one in its done cycle.
`default_nettype none
`include "assert_macros.svh"

module easing_curve_interpolator #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] start_value,
  input  wire logic signed [15:0] end_value,
  input  wire logic [16:0]        progress,
  input  wire logic [2:0]         curve,
  input  wire logic [1:0]         mode,
  output logic                    done,
  output logic signed [16:0]      eased_value
);

  localparam int F   = FRACTION_BITS;
  localparam int W   = F + 8;
  localparam int TW  = F + 1;
  localparam int CTW = $bits(eci_pkg::ctl_t);
  localparam int QW  = CTW + W + TW + 16 + 17;
  localparam int LAT = F + 10;

  logic                q_full;
  logic                q_empty;
  logic                push;
  logic signed [W-1:0] f_x;
  logic [TW-1:0]       f_t;
  logic signed [15:0]  f_base;
  logic signed [16:0]  f_diff;
  eci_pkg::ctl_t       f_ctl;
  logic [QW-1:0]       q_din;
  logic [QW-1:0]       q_dout;
  logic signed [W-1:0] b_x;
  logic [TW-1:0]       b_t;
  logic signed [15:0]  b_base;
  logic signed [16:0]  b_diff;
  eci_pkg::ctl_t       b_ctl;

  eci_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .start_value(start_value),
    .end_value  (end_value),
    .progress   (progress),
    .curve      (curve),
    .mode       (mode),
    .q_full     (q_full),
    .push       (push),
    .x          (f_x),
    .t          (f_t),
    .base       (f_base),
    .diff       (f_diff),
    .ctl        (f_ctl)
  );

  // pack the classified beat for the queue
  assign q_din = {f_ctl, f_x, f_t, f_base, f_diff};
  assign {b_ctl, b_x, b_t, b_base, b_diff} = q_dout;

  eci_queue #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .pop  (!q_empty),
    .dout (q_dout),
    .empty(q_empty),
    .full (q_full)
  );

  eci_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .x          (b_x),
    .t          (b_t),
    .base       (b_base),
    .diff       (b_diff),
    .ctl        (b_ctl),
    .done       (done),
    .eased_value(eased_value)
  );

  `ECI_ASSERT_IMPL(a_latency, $past(start && !busy, LAT), done, "accepted beat gave no result")
  `ECI_ASSERT_IMPL(a_no_extra, done, $past(start && !busy, LAT), "result without a beat")
  `ECI_ASSERT(a_never_busy, !busy, "front end stalled although the back end drains every cycle")

endmodule

`default_nettype wire

>>> bench/tb_easing_curve_interpolator.sv
// Testbench for easing_curve_interpolator: drives random and corner beats and
// checks every result against an in-bench fixed-point model of the curves.
// Depends on eci_pkg and the easing_curve_interpolator RTL.
`timescale 1ns / 100ps

class eased_scoreboard;
  localparam int FB = 16;
  longint unsigned err_count;
  logic signed [16:0] pending_q[$];

  function new();
    err_count = 0;
  endfunction

  static function longint round_shift(longint x, int s);
    longint m;
    if (s == 0) return x;
    m = (x < 0) ? -x : x;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (x < 0) ? -m : m;
  endfunction

  static function longint fmul(longint a, longint b);
    return round_shift(a * b, FB);
  endfunction

  static function longint fconst(longint num, longint den);
    return ((num << FB) + den / 2) / den;
  endfunction

  static function longint fpow(longint x, int n);
    longint r;
    r = x;
    for (int i = 1; i < n; i++) r = fmul(r, x);
    return r;
  endfunction

  static function longint fsqrt(longint x);
    longint lo, hi, mid, v;
    if (x <= 0) return 0;
    v = x << FB;
    lo = 0;
    hi = 64'd4294967296;
    // binary search for floor(sqrt(v))
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  static function longint bounce_out(longint t);
    longint one, v, base;
    int sh;
    one = longint'(1) << FB;
    sh = 4;
    if (11 * t < 4 * one) begin v = 11 * t; base = 0; end
    else if (11 * t < 8 * one) begin v = 11 * t - 6 * one; base = fconst(3, 4); end
    else if (11 * t < 10 * one) begin v = 11 * t - 9 * one; base = fconst(15, 16); end
    else begin v = 22 * t - 21 * one; base = fconst(63, 64); sh = 6; end
    sh += FB;
    return ((v * v + (longint'(1) << (sh - 1))) >>> sh) + base;
  endfunction

  static function longint bounce_in(longint t);
    return (longint'(1) << FB) - bounce_out((longint'(1) << FB) - t);
  endfunction

  static function longint curve_weight(longint t, logic [2:0] crv, logic [1:0] md);
    longint one, c1, c3, c2, c2p, s, u;
    bit low;
    int n;
    one = longint'(1) << FB;
    c1 = fconst(170158, 100000);
    c3 = fconst(270158, 100000);
    c2 = fconst(25949095, 10000000);
    c2p = fconst(35949095, 10000000);
    low = t < (one >> 1);
    if (md > eci_pkg::MODE_IN_OUT) md = eci_pkg::MODE_IN_OUT;
    case (crv) inside
      eci_pkg::CURVE_BACK: begin
        if (md == eci_pkg::MODE_IN) return fmul(c3, fpow(t, 3)) - fmul(c1, fpow(t, 2));
        if (md == eci_pkg::MODE_OUT) begin
          s = t - one;
          return one + fmul(c3, fpow(s, 3)) + fmul(c1, fpow(s, 2));
        end
        if (low) begin
          u = 2 * t;
          return round_shift(fmul(fpow(u, 2), fmul(c2p, u) - c2), 1);
        end
        u = 2 * t - 2 * one;
        return round_shift(fmul(fpow(u, 2), fmul(c2p, u) + c2) + 2 * one, 1);
      end
      eci_pkg::CURVE_BOUNCE: begin
        if (md == eci_pkg::MODE_IN) return bounce_in(t);
        if (md == eci_pkg::MODE_OUT) return bounce_out(t);
        if (low) return round_shift(bounce_in(2 * t), 1);
        return round_shift(bounce_out(2 * t - one), 1) + (one >> 1);
      end
      eci_pkg::CURVE_CIRC: begin
        if (md == eci_pkg::MODE_IN) return one - fsqrt(one - fpow(t, 2));
        if (md == eci_pkg::MODE_OUT) return fsqrt(one - fpow(t - one, 2));
        if (low) return round_shift(one - fsqrt(one - fpow(2 * t, 2)), 1);
        return round_shift(fsqrt(one - fpow(2 * t - 2 * one, 2)) + one, 1);
      end
      eci_pkg::CURVE_QUINT, eci_pkg::CURVE_CUBIC: begin
        n = (crv == eci_pkg::CURVE_QUINT) ? 5 : 3;
        if (md == eci_pkg::MODE_IN) return fpow(t, n);
        if (md == eci_pkg::MODE_OUT) return one - fpow(one - t, n);
        if (low) return round_shift(fpow(2 * t, n), 1);
        return one - round_shift(fpow(2 * one - 2 * t, n), 1);
      end
      default: return t;
    endcase
  endfunction

  // Note an accepted beat and queue its eased value
  function void note_beat(logic signed [15:0] sv, logic signed [15:0] ev,
                          logic [16:0] prog, logic [2:0] crv, logic [1:0] md);
    longint t, w, r;
    t = (prog > 17'd65536) ? 65536 : longint'(prog);
    w = curve_weight(t, crv, md);
    r = longint'(sv) + round_shift((longint'(ev) - longint'(sv)) * w, FB);
    if (r < eci_pkg::OUT_LOW) r = eci_pkg::OUT_LOW;
    if (r > eci_pkg::OUT_HIGH) r = eci_pkg::OUT_HIGH;
    pending_q.push_back(r[16:0]);
  endfunction

  // Compare a result strobe against the oldest pending value
  function void check_result(logic signed [16:0] got);
    logic signed [16:0] want;
    if (pending_q.size() == 0) begin
      $error("eased_value: unexpected result %0d", got);
      err_count++;
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      $error("eased_value: expected %0d, actual %0d", want, got);
      err_count++;
    end
  endfunction
endclass

module tb_easing_curve_interpolator;
  logic clk, rst, start, busy, done;
  logic signed [15:0] start_value, end_value;
  logic [16:0] progress;
  logic [2:0] curve;
  logic [1:0] mode;
  logic signed [16:0] eased_value;
  eased_scoreboard board;
  bit gaps_on;

  easing_curve_interpolator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_value(start_value), .end_value(end_value), .progress(progress),
    .curve(curve), .mode(mode), .done(done), .eased_value(eased_value)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample result strobes
  always @(posedge clk) begin
    if (!rst && done) board.check_result(eased_value);
  end

  // Present one beat and hold it until taken
  task automatic send_beat(logic signed [15:0] sv, logic signed [15:0] ev,
                           logic [16:0] prog, logic [2:0] crv, logic [1:0] md);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    start_value <= sv;
    end_value <= ev;
    progress <= prog;
    curve <= crv;
    mode <= md;
    do @(posedge clk); while (busy);
    board.note_beat(sv, ev, prog, crv, md);
    @(negedge clk);
  endtask

  function automatic logic [16:0] pick_progress();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'(32767 + $urandom_range(0, 2));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int waited;
    logic [16:0] dir_prog[6];
    board = new();
    rst = 1;
    start = 0;
    start_value = 0;
    end_value = 0;
    progress = 0;
    curve = 0;
    mode = 0;
    gaps_on = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // Directed: the back curve in all three modes at corner progress values, then the other curves, plus odd codes
    dir_prog = '{17'd0, 17'd16384, 17'd32767, 17'd32768, 17'd65536, 17'h1FFFF};
    foreach (dir_prog[i]) begin
      send_beat(16'sh8000, 16'sh7FFF, dir_prog[i], eci_pkg::CURVE_BACK, 2'(i % 3));
    end
    send_beat(16'sh7FFF, 16'sh8000, 17'd13107, eci_pkg::CURVE_BACK, eci_pkg::MODE_IN);
    send_beat(16'sh8000, 16'sh7FFF, 17'd52428, eci_pkg::CURVE_BACK, eci_pkg::MODE_OUT);
    send_beat(-16'sd1000, 16'sd1000, 17'd23831, eci_pkg::CURVE_BOUNCE, eci_pkg::MODE_OUT);
    send_beat(-16'sd1000, 16'sd1000, 17'd47662, eci_pkg::CURVE_BOUNCE, eci_pkg::MODE_OUT);
    send_beat(-16'sd1000, 16'sd1000, 17'd59578, eci_pkg::CURVE_BOUNCE, 2'd3);
    send_beat(16'sd0, 16'sd30000, 17'd40000, eci_pkg::CURVE_CIRC, eci_pkg::MODE_IN_OUT);
    send_beat(16'sd0, 16'sd30000, 17'd20000, eci_pkg::CURVE_QUINT, eci_pkg::MODE_IN_OUT);
    send_beat(16'sd0, 16'sd30000, 17'd50000, eci_pkg::CURVE_CUBIC, eci_pkg::MODE_IN_OUT);
    send_beat(16'sd5, 16'sd20000, 17'd30000, 3'd5, eci_pkg::MODE_IN);
    send_beat(16'sd5, 16'sd20000, 17'd30000, 3'd7, 2'd3);
    // Random: gaps in the first part, back-to-back at the end
    gaps_on = 1;
    for (int n = 0; n < 1150; n++) begin
      if (n == 950) gaps_on = 0;
      send_beat(16'($urandom), 16'($urandom), pick_progress(),
                ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4)),
                2'($urandom_range(0, 3)));
    end
    start <= 0;
    waited = 0;
    while (board.pending_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (board.err_count == 0 && board.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/eci_pkg.sv
sv/eci_front.sv
sv/eci_queue.sv
sv/eci_back.sv
sv/easing_curve_interpolator.sv
bench/tb_easing_curve_interpolator.sv
